>>> sv/nmea_rmc_sentence_validator_top_macros.svh
// ----------------------------------------------------------------------------
// NMEA RMC validator assertion macros
// Shared property forms for the concurrent checks of the validator.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_SENTENCE_VALIDATOR_TOP_MACROS_SVH
`define NMEA_RMC_SENTENCE_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NRMC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrmc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NRMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrmc: next-cycle check failed");

`endif

>>> sv/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC validator package
// Types, constants and character helpers shared by the validator modules.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	// Default sizing of a sentence and its fields.
	localparam int MaxLineDef   = 80;
	localparam int FieldLenDef  = 16;
	localparam int NumFieldsDef = 13;

	// Widths of the parse state, and the header length.
	localparam int LineW  = 7;
	localparam int PosW   = 5;
	localparam int FieldW = 4;
	localparam int HdrLen = 6;

	// Field position that marks a field as closed after the last comma.
	localparam logic [PosW-1:0] PosDrop = '1;

	// Characters that steer the parser.
	localparam logic [7:0] ChDollar  = 8'h24;
	localparam logic [7:0] ChStar    = 8'h2A;
	localparam logic [7:0] ChComma   = 8'h2C;
	localparam logic [7:0] ChNewline = 8'h0A;

	// Checksum parse phase.
	typedef enum logic [1:0] {
		PH_BEFORE_STAR = 2'd0,
		PH_DIGITS      = 2'd1,
		PH_TAKEN       = 2'd2,
		PH_BAD         = 2'd3
	} phase_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic [3:0] field_index;
		logic [3:0] char_index;
		logic       sentence_end;
		logic       sentence_ok;
	} result_t;

	// Value of a hex digit in either case; bit 4 set means not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = 5'd9 + {2'b00, c[2:0]};
		end
		return v;
	endfunction

	// Expected header character at a position, GP talker.
	function automatic logic [7:0] hdr_gp_char(input logic [2:0] p);
		logic [7:0] c;
		unique case (p)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Expected header character at a position, GN talker.
	function automatic logic [7:0] hdr_gn_char(input logic [2:0] p);
		logic [7:0] c;
		unique case (p)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h4E;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> sv/nrmc_parse.sv
// ----------------------------------------------------------------------------
// NMEA RMC parse step
// Holds the sentence state and computes the result of one byte in one pass.
// ----------------------------------------------------------------------------
module nrmc_parse import nrmc_pkg::*; #(
	parameter int MAX_LINE   = MaxLineDef,
	parameter int FIELD_LEN  = FieldLenDef,
	parameter int NUM_FIELDS = NumFieldsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    res
);

	localparam logic [LineW-1:0]  LineLast = LineW'(MAX_LINE - 1);
	localparam logic [PosW-1:0]   PosLast  = PosW'(FIELD_LEN - 1);
	localparam logic [FieldW:0]   FieldCnt = (FieldW + 1)'(NUM_FIELDS);

	logic              in_sentence_q, in_sentence_d;
	logic [LineW-1:0]  line_count_q, line_count_d;
	logic [7:0]        running_xor_q, running_xor_d;
	phase_t            phase_q, phase_d;
	logic [7:0]        given_sum_q, given_sum_d;
	logic [1:0]        digits_q, digits_d;
	logic              gp_match_q, gp_match_d;
	logic              gn_match_q, gn_match_d;
	logic [FieldW-1:0] field_q, field_d;
	logic [PosW-1:0]   pos_q, pos_d;
	logic [4:0]        hex_d;
	logic [FieldW:0]   field_next;

	assign hex_d      = hex_value(rx_byte);
	assign field_next = {1'b0, field_q} + 1'b1;

	// Next state and result for the byte at hand.
	always_comb begin
		in_sentence_d = in_sentence_q;
		line_count_d  = line_count_q;
		running_xor_d = running_xor_q;
		phase_d       = phase_q;
		given_sum_d   = given_sum_q;
		digits_d      = digits_q;
		gp_match_d    = gp_match_q;
		gn_match_d    = gn_match_q;
		field_d       = field_q;
		pos_d         = pos_q;
		res           = '0;
		res.out_char  = rx_byte;
		if (rx_byte == ChDollar) begin
			// A dollar always opens a fresh sentence as character 0 of field 0.
			in_sentence_d  = 1'b1;
			line_count_d   = LineW'(1);
			running_xor_d  = '0;
			phase_d        = PH_BEFORE_STAR;
			given_sum_d    = '0;
			digits_d       = '0;
			gp_match_d     = 1'b1;
			gn_match_d     = 1'b1;
			field_d        = '0;
			pos_d          = PosW'(1);
			res.char_valid = 1'b1;
		end else if (in_sentence_q) begin
			if (line_count_q >= LineLast) begin
				// Line too long: drop the sentence silently.
				in_sentence_d = 1'b0;
			end else begin
				line_count_d = line_count_q + 1'b1;
				if (line_count_q < LineW'(HdrLen)) begin
					if (rx_byte != hdr_gp_char(line_count_q[2:0])) gp_match_d = 1'b0;
					if (rx_byte != hdr_gn_char(line_count_q[2:0])) gn_match_d = 1'b0;
				end
				if (rx_byte == ChNewline) begin
					res.sentence_end = 1'b1;
					res.sentence_ok  = (gp_match_q | gn_match_q) && phase_q == PH_TAKEN &&
						given_sum_q == running_xor_q;
					in_sentence_d    = 1'b0;
				end else if (phase_q == PH_BEFORE_STAR) begin
					if (rx_byte == ChStar) begin
						phase_d = PH_DIGITS;
					end else begin
						running_xor_d = running_xor_q ^ rx_byte;
						if (rx_byte == ChComma) begin
							if (field_next < FieldCnt) begin
								field_d = field_next[FieldW-1:0];
								pos_d   = '0;
							end else begin
								pos_d = PosDrop;
							end
						end else if (pos_q < PosLast) begin
							res.char_valid  = 1'b1;
							res.field_index = field_q;
							res.char_index  = pos_q[3:0];
							pos_d           = pos_q + 1'b1;
						end
					end
				end else if (phase_q == PH_DIGITS) begin
					if (hex_d[4]) begin
						phase_d = PH_BAD;
					end else begin
						given_sum_d = {given_sum_q[3:0], hex_d[3:0]};
						digits_d    = digits_q + 1'b1;
						if (digits_q + 1'b1 >= 2'd2) phase_d = PH_TAKEN;
					end
				end else if (phase_q == PH_TAKEN && digits_q == 2'd2) begin
					// A third hex digit spoils the checksum; anything else closes it.
					if (!hex_d[4]) phase_d = PH_BAD;
					else digits_d = 2'd3;
				end
			end
		end
	end

	// Sentence state, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			line_count_q  <= '0;
			running_xor_q <= '0;
			phase_q       <= PH_BEFORE_STAR;
			given_sum_q   <= '0;
			digits_q      <= '0;
			gp_match_q    <= 1'b1;
			gn_match_q    <= 1'b1;
			field_q       <= '0;
			pos_q         <= '0;
		end else if (step) begin
			in_sentence_q <= in_sentence_d;
			line_count_q  <= line_count_d;
			running_xor_q <= running_xor_d;
			phase_q       <= phase_d;
			given_sum_q   <= given_sum_d;
			digits_q      <= digits_d;
			gp_match_q    <= gp_match_d;
			gn_match_q    <= gn_match_d;
			field_q       <= field_d;
			pos_q         <= pos_d;
		end
	end

endmodule

>>> sv/nmea_rmc_sentence_validator_top.sv
// ----------------------------------------------------------------------------
// NMEA RMC sentence validator
// Byte stream in, one tagged result beat out per byte, with a verdict at '\n'.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while the output is not stalled
// and returns one result beat per byte: the byte is registered, passes once
// through the parse step that also updates the sentence state, and lands in
// the output register. The input stays ready while a result waits, as long as
// the input register is free. A result with tlast set closes a sentence; tuser
// then says whether the header was $GPRMC or $GNRMC and the two-digit checksum
// matched, and only then should stored fields be kept.
`include "nmea_rmc_sentence_validator_top_macros.svh"

module nmea_rmc_sentence_validator_top import nrmc_pkg::*; #(
	parameter int MAX_LINE   = MaxLineDef,
	parameter int FIELD_LEN  = FieldLenDef,
	parameter int NUM_FIELDS = NumFieldsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_char, [8] char_valid, [12:9] field_index, [16:13] char_index
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast,  // sentence_end
	output logic        m_axis_tuser   // sentence_ok
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;
	logic       step;

	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	nrmc_parse #(
		.MAX_LINE  (MAX_LINE),
		.FIELD_LEN (FIELD_LEN),
		.NUM_FIELDS(NUM_FIELDS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(byte_s1),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, res_s2.char_index, res_s2.field_index,
		res_s2.char_valid, res_s2.out_char};
	assign m_axis_tlast  = res_s2.sentence_end;
	assign m_axis_tuser  = res_s2.sentence_ok;

	// A good verdict only comes with the closing newline.
	`NRMC_ASSERT_IMP(a_ok_needs_end, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	// The closing newline is never stored as a field character.
	`NRMC_ASSERT_IMP(a_end_not_char, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[8])
	// Stored characters always land in an existing field.
	`NRMC_ASSERT_IMP(a_field_range, m_axis_tvalid && m_axis_tdata[8],
		m_axis_tdata[12:9] < 4'(NUM_FIELDS))
	// A full input register behind a stalled output holds off new bytes.
	`NRMC_ASSERT_IMP(a_backpressure, valid_s1 && valid_s2 && !m_axis_tready, !s_axis_tready)
	// A stalled result beat stays on the bus unchanged.
	`NRMC_ASSERT_NEXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule
